@@ rtl/dhts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhts_pkg
// Shared types, codes and constants of the double-hashing string-key table.
// ----------------------------------------------------------------------------
package dhts_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_TABLE_DEPTH  = 16;
    localparam int DEF_KEY_BYTES    = 8;

    // Fixed field widths
    localparam int KEY_TEXT_W       = 63;
    localparam int ITEM_W           = 32;
    localparam int MODE_W           = 2;
    localparam int STATUS_W         = 2;
    localparam int CFG_W            = 5;
    localparam int RESET_TABLE_SIZE = 11;

    // Byte sum of up to eight bytes stays below 2048
    localparam int HASH_W           = 11;

    // Probe step is 7 - (hash mod 7), range 1..7
    localparam int STEP_MOD         = 7;
    localparam int STEP_W           = 3;

    // hash / 7 == (hash * 2341) >> 14 for every hash below 2048
    localparam int RECIP7           = 2341;
    localparam int RECIP7_SHIFT     = 14;
    localparam int RECIP7_PROD_W    = HASH_W + 12;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_FIND   = 2'd1,
        MODE_UPDATE = 2'd2,
        MODE_REMOVE = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_NO_SLOT   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_MOD,
        S_START,
        S_CHECK,
        S_RESP
    } ctrl_state_t;

    // Per-slot marks held in the flag memory
    typedef struct packed {
        logic ever_used;
        logic occupied;
    } slot_flags_t;

    // Write strobes from the controller to the slot store
    typedef struct packed {
        logic kv_we;
        logic flags_we;
    } store_wr_t;

endpackage

@@ rtl/dhts_hash.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhts_hash
// Key canonicalization and byte-sum hash, plus the probe step 7 - hash mod 7.
// ----------------------------------------------------------------------------
module dhts_hash #(
    parameter int KEY_BYTES = dhts_pkg::DEF_KEY_BYTES
) (
    input  logic                             aclk,
    input  logic                             load,
    input  logic [dhts_pkg::KEY_TEXT_W-1:0]  key_text,
    output logic [8*KEY_BYTES-1:0]           key_canon,
    output logic [dhts_pkg::HASH_W-1:0]      hash_val,
    output logic [dhts_pkg::STEP_W-1:0]      step_val
);
    import dhts_pkg::*;

    localparam int KEY_W   = 8 * KEY_BYTES;
    localparam int QUOT_W  = RECIP7_PROD_W - RECIP7_SHIFT;

    logic [63:0]              text64;
    logic [7:0]               byte_v;
    logic                     alive;
    logic [KEY_W-1:0]         canon;
    logic [HASH_W-1:0]        sum;
    logic [KEY_W-1:0]         key_reg;
    logic [HASH_W-1:0]        hash_reg;
    logic [RECIP7_PROD_W-1:0] prod;
    logic [QUOT_W-1:0]        quot;
    logic [HASH_W-1:0]        rem7;

    assign text64 = {1'b0, key_text};

    // Bytes up to the first zero byte are kept and summed, the rest cleared
    always_comb begin
        alive  = 1'b1;
        canon  = '0;
        sum    = '0;
        byte_v = '0;
        for (int b = 0; b < KEY_BYTES; b++) begin
            byte_v = text64[8*b +: 8];
            if (byte_v == 8'd0) begin
                alive = 1'b0;
            end
            if (alive) begin
                canon[8*b +: 8] = byte_v;
                sum             = sum + HASH_W'(byte_v);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            key_reg  <= canon;
            hash_reg <= sum;
        end
    end

    // hash mod 7 through a reciprocal multiply
    assign prod     = RECIP7_PROD_W'(hash_reg) * RECIP7_PROD_W'(RECIP7);
    assign quot     = prod[RECIP7_PROD_W-1:RECIP7_SHIFT];
    assign rem7     = hash_reg - HASH_W'(HASH_W'(quot) * HASH_W'(STEP_MOD));
    assign step_val = STEP_W'(STEP_MOD) - rem7[STEP_W-1:0];

    assign key_canon = key_reg;
    assign hash_val  = hash_reg;

endmodule

@@ rtl/dhts_rem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhts_rem
// Restoring remainder unit: one dividend bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module dhts_rem #(
    parameter int DIVIDEND_W = dhts_pkg::HASH_W,
    parameter int DIVISOR_W  = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic [DIVISOR_W-1:0]  remainder
);
    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVIDEND_W-1:0] dvd_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W-1:0]  rem_next;

    // Shift in the next dividend bit, subtract when it fits
    always_comb begin
        trial = {rem_reg, dvd_reg[DIVIDEND_W-1]};
        if (trial >= {1'b0, dvs_reg}) begin
            rem_next = DIVISOR_W'(trial - {1'b0, dvs_reg});
        end else begin
            rem_next = DIVISOR_W'(trial);
        end
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIVIDEND_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_reg << 1;
        end
    end

    assign busy      = busy_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/dhts_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhts_store
// Slot memories: key/item memory and flag memory, each with a registered read.
// The flag memory is cleared by a sweep after reset.
// ----------------------------------------------------------------------------
module dhts_store #(
    parameter int TABLE_DEPTH = dhts_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_W       = 8 * dhts_pkg::DEF_KEY_BYTES
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              rd_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0]    rd_addr,
    input  dhts_pkg::store_wr_t               wr,
    input  logic [$clog2(TABLE_DEPTH)-1:0]    wr_addr,
    input  logic [KEY_W+dhts_pkg::ITEM_W-1:0] kv_wdata,
    input  dhts_pkg::slot_flags_t             flags_wdata,
    output logic [KEY_W+dhts_pkg::ITEM_W-1:0] kv_rdata,
    output dhts_pkg::slot_flags_t             flags_rdata,
    output logic                              clear_busy
);
    import dhts_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int KV_W  = KEY_W + ITEM_W;

    logic [KV_W-1:0] kv_mem [TABLE_DEPTH];
    slot_flags_t     flag_mem [TABLE_DEPTH];
    logic [KV_W-1:0] kv_rdata_reg;
    slot_flags_t     flags_rdata_reg;
    logic            clear_busy_reg;
    logic [IDX_W-1:0] clr_ptr_reg;

    // Clearing sweep over the flag memory
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_busy_reg <= 1'b1;
            clr_ptr_reg    <= '0;
        end else if (clear_busy_reg) begin
            clr_ptr_reg <= clr_ptr_reg + IDX_W'(1);
            if (clr_ptr_reg == IDX_W'(TABLE_DEPTH - 1)) begin
                clear_busy_reg <= 1'b0;
            end
        end
    end

    // Key/item memory
    always_ff @(posedge aclk) begin
        if (wr.kv_we) begin
            kv_mem[wr_addr] <= kv_wdata;
        end
        if (rd_en) begin
            kv_rdata_reg <= kv_mem[rd_addr];
        end
    end

    // Flag memory
    always_ff @(posedge aclk) begin
        if (clear_busy_reg) begin
            flag_mem[clr_ptr_reg] <= '0;
        end else if (wr.flags_we) begin
            flag_mem[wr_addr] <= flags_wdata;
        end
        if (rd_en) begin
            flags_rdata_reg <= flag_mem[rd_addr];
        end
    end

    assign kv_rdata    = kv_rdata_reg;
    assign flags_rdata = flags_rdata_reg;
    assign clear_busy  = clear_busy_reg;

endmodule

@@ rtl/dhts_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhts_ctrl
// Operation sequencer: probe walk over the slot store, entry count and the
// result register.
// ----------------------------------------------------------------------------
module dhts_ctrl #(
    parameter int TABLE_DEPTH = dhts_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_W       = 8 * dhts_pkg::DEF_KEY_BYTES
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [dhts_pkg::MODE_W-1:0]           s_mode,
    input  logic [dhts_pkg::ITEM_W-1:0]           s_item_value,
    // result channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [dhts_pkg::STATUS_W-1:0]         m_status,
    output logic [$clog2(TABLE_DEPTH)-1:0]        m_slot_index,
    output logic [dhts_pkg::ITEM_W-1:0]           m_item_out,
    // table size in use
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]      size,
    // hash unit
    input  logic [KEY_W-1:0]                      key_canon,
    // remainder units
    output logic                                  rem_start,
    input  logic                                  h_busy,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]      h_rem,
    input  logic                                  st_busy,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]      st_rem,
    // slot store
    output logic                                  rd_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]        rd_addr,
    output dhts_pkg::store_wr_t                   wr,
    output logic [$clog2(TABLE_DEPTH)-1:0]        wr_addr,
    output logic [KEY_W+dhts_pkg::ITEM_W-1:0]     kv_wdata,
    output dhts_pkg::slot_flags_t                 flags_wdata,
    input  logic [KEY_W+dhts_pkg::ITEM_W-1:0]     kv_rdata,
    input  dhts_pkg::slot_flags_t                 flags_rdata,
    input  logic                                  clear_busy
);
    import dhts_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int SZ_W   = $clog2(TABLE_DEPTH + 1);
    localparam int PSUM_W = SZ_W + 1;

    ctrl_state_t        state_reg, state_next;
    mode_t              mode_reg;
    logic [ITEM_W-1:0]  item_reg;
    logic [SZ_W-1:0]    count_reg;
    logic [IDX_W-1:0]   pos_reg;
    logic [IDX_W-1:0]   stepm_reg;
    logic [SZ_W-1:0]    cnt_reg;
    status_t            res_status_reg;
    logic [IDX_W-1:0]   res_slot_reg;
    logic [ITEM_W-1:0]  res_item_reg;
    logic               m_valid_reg;
    status_t            m_status_reg;
    logic [IDX_W-1:0]   m_slot_reg;
    logic [ITEM_W-1:0]  m_item_reg;

    logic               accept;
    logic               table_full;
    logic               mod_done;
    logic               out_load;
    logic               res_ok;
    logic [PSUM_W-1:0]  pos_sum;
    logic [IDX_W-1:0]   pos_next;
    logic               probe_last;
    logic               key_eq;
    logic [ITEM_W-1:0]  stored_item;
    logic               hit_done;
    status_t            hit_status;
    logic [ITEM_W-1:0]  hit_item;

    assign accept     = s_valid && s_ready;
    assign table_full = (mode_reg == MODE_INSERT) && (count_reg >= size);
    assign mod_done   = !h_busy && !st_busy;
    assign res_ok     = (res_status_reg == ST_OK);

    // Next probe position: pos + step, wrapped once (both below size)
    always_comb begin
        pos_sum = PSUM_W'(pos_reg) + PSUM_W'(stepm_reg);
        if (pos_sum >= PSUM_W'(size)) begin
            pos_next = IDX_W'(pos_sum - PSUM_W'(size));
        end else begin
            pos_next = IDX_W'(pos_sum);
        end
    end

    // Evaluate the slot read in the previous cycle
    assign probe_last  = (cnt_reg == size - SZ_W'(1));
    assign key_eq      = (kv_rdata[KEY_W+ITEM_W-1:ITEM_W] == key_canon);
    assign stored_item = kv_rdata[ITEM_W-1:0];

    always_comb begin
        hit_done   = 1'b0;
        hit_status = ST_OK;
        hit_item   = stored_item;
        if (mode_reg == MODE_INSERT) begin
            if (!flags_rdata.occupied) begin
                hit_done = 1'b1;
                hit_item = item_reg;
            end else if (probe_last) begin
                hit_done   = 1'b1;
                hit_status = ST_NO_SLOT;
            end
        end else begin
            if (!flags_rdata.ever_used) begin
                hit_done   = 1'b1;
                hit_status = ST_NOT_FOUND;
            end else if (flags_rdata.occupied && key_eq) begin
                hit_done = 1'b1;
                if (mode_reg == MODE_UPDATE) begin
                    hit_item = item_reg;
                end
            end else if (probe_last) begin
                hit_done   = 1'b1;
                hit_status = ST_NOT_FOUND;
            end
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_HASH;
                end
            end
            S_HASH: begin
                state_next = table_full ? S_RESP : S_MOD;
            end
            S_MOD: begin
                if (mod_done) begin
                    state_next = S_START;
                end
            end
            S_START: begin
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (hit_done) begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        s_ready     = 1'b0;
        rem_start   = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = pos_reg;
        out_load    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = !clear_busy;
            end
            S_HASH: begin
                rem_start = !table_full;
            end
            S_START: begin
                rd_en = 1'b1;
            end
            S_CHECK: begin
                rd_en   = !hit_done;
                rd_addr = pos_next;
            end
            S_RESP: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Store write-back happens as the result register is loaded
    assign wr.kv_we    = out_load && res_ok &&
                         (mode_reg == MODE_INSERT || mode_reg == MODE_UPDATE);
    assign wr.flags_we = out_load && res_ok &&
                         (mode_reg == MODE_INSERT || mode_reg == MODE_REMOVE);
    assign wr_addr     = res_slot_reg;
    assign kv_wdata    = {key_canon, item_reg};
    assign flags_wdata = '{ever_used: 1'b1, occupied: (mode_reg == MODE_INSERT)};

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (out_load && res_ok && mode_reg == MODE_INSERT) begin
                count_reg <= count_reg + SZ_W'(1);
            end else if (out_load && res_ok && mode_reg == MODE_REMOVE &&
                         count_reg != '0) begin
                count_reg <= count_reg - SZ_W'(1);
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg <= mode_t'(s_mode);
            item_reg <= s_item_value;
        end
        if (state_reg == S_HASH && table_full) begin
            res_status_reg <= ST_FULL;
            res_slot_reg   <= '0;
            res_item_reg   <= '0;
        end
        if (state_reg == S_MOD && mod_done) begin
            pos_reg   <= IDX_W'(h_rem);
            stepm_reg <= IDX_W'(st_rem);
            cnt_reg   <= '0;
        end
        if (state_reg == S_CHECK) begin
            if (hit_done) begin
                res_status_reg <= hit_status;
                res_slot_reg   <= (hit_status == ST_OK) ? pos_reg : '0;
                res_item_reg   <= (hit_status == ST_OK) ? hit_item : '0;
            end else begin
                pos_reg <= pos_next;
                cnt_reg <= cnt_reg + SZ_W'(1);
            end
        end
        if (out_load) begin
            m_status_reg <= res_status_reg;
            m_slot_reg   <= res_slot_reg;
            m_item_reg   <= res_item_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_slot_index = m_slot_reg;
    assign m_item_out   = m_item_reg;

    // No item is taken while the flag sweep runs
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !clear_busy)
        else $error("input taken during flag clear");

    // Entry count bounded by the table depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= TABLE_DEPTH)
        else $error("entry count above table depth");

    // Probe walk never goes past table_size probes
    a_probe_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHECK) |-> (cnt_reg < size))
        else $error("probe count overrun");

    // Failed operations report slot and item as zero
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != ST_OK) |->
        (m_slot_reg == '0 && m_item_reg == '0))
        else $error("nonzero slot or item on failure");

    // A loaded result ends the operation
    a_load_ends_op: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (m_valid_reg && state_reg == S_IDLE))
        else $error("result load did not return to idle");

endmodule

@@ rtl/double_hash_table_string_keys.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_hash_table_string_keys
// Open-addressing hash table with string keys and double hashing.
//
// Usage:
//   s_* channel: one beat is one operation (insert, find, update, remove)
//   with its key string and item. m_* channel: one beat per operation with
//   status, slot index and item. cfg_* channel: table_size, to be written
//   only while no operation is in flight (the user's duty; the block does
//   not enforce it); 0 is taken as 1 and values above TABLE_DEPTH as
//   TABLE_DEPTH. An operation runs through hashing, hash mod table_size
//   and step mod table_size in the bit-serial remainder units (11 steps
//   for the hash), the issue of the first read, one memory probe per cycle
//   (1..table_size probes) and the load of the result. An insert into a
//   full table goes from hashing straight to loading the result.
//   One operation is in flight at a time, so the block takes no new beat
//   until it has loaded the result of the last one; the next beat is taken
//   in the cycle after the result register is loaded, even while that
//   result still waits on m_ready. A stalled receiver holds the block in
//   its response step until the result register frees up.
//   Reset: after aresetn the flag memory is swept clear with s_ready low;
//   table_size returns to 11 (TABLE_DEPTH if that is smaller) and the
//   entry count to 0.
// ----------------------------------------------------------------------------
module double_hash_table_string_keys #(
    parameter int TABLE_DEPTH = dhts_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_BYTES   = dhts_pkg::DEF_KEY_BYTES
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dhts_pkg::CFG_W-1:0]           cfg_table_size,
    // input channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [dhts_pkg::MODE_W-1:0]          s_mode,
    input  logic [dhts_pkg::KEY_TEXT_W-1:0]      s_key_text,
    input  logic signed [dhts_pkg::ITEM_W-1:0]   s_item_value,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [dhts_pkg::STATUS_W-1:0]        m_status,
    output logic [$clog2(TABLE_DEPTH)-1:0]       m_slot_index,
    output logic signed [dhts_pkg::ITEM_W-1:0]   m_item_out
);
    import dhts_pkg::*;

    localparam int IDX_W      = $clog2(TABLE_DEPTH);
    localparam int SZ_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W      = 8 * KEY_BYTES;
    localparam int RESET_SIZE = (RESET_TABLE_SIZE > TABLE_DEPTH) ?
                                TABLE_DEPTH : RESET_TABLE_SIZE;

    logic [SZ_W-1:0]         size_reg, size_next;
    logic                    hash_load;
    logic [KEY_W-1:0]        key_canon;
    logic [HASH_W-1:0]       hash_val;
    logic [STEP_W-1:0]       step_val;
    logic                    rem_start;
    logic                    h_busy;
    logic [SZ_W-1:0]         h_rem;
    logic                    st_busy;
    logic [SZ_W-1:0]         st_rem;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    store_wr_t               wr;
    logic [IDX_W-1:0]        wr_addr;
    logic [KEY_W+ITEM_W-1:0] kv_wdata;
    slot_flags_t             flags_wdata;
    logic [KEY_W+ITEM_W-1:0] kv_rdata;
    slot_flags_t             flags_rdata;
    logic                    clear_busy;
    logic [ITEM_W-1:0]       item_out;

    // Table size register with clamping
    assign cfg_ready = 1'b1;

    always_comb begin
        size_next = size_reg;
        if (cfg_valid && cfg_ready) begin
            if (cfg_table_size == '0) begin
                size_next = SZ_W'(1);
            end else if (32'(cfg_table_size) > TABLE_DEPTH) begin
                size_next = SZ_W'(TABLE_DEPTH);
            end else begin
                size_next = SZ_W'(cfg_table_size);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SZ_W'(RESET_SIZE);
        end else begin
            size_reg <= size_next;
        end
    end

    assign hash_load = s_valid && s_ready;

    dhts_hash #(
        .KEY_BYTES (KEY_BYTES)
    ) u_hash (
        .aclk      (aclk),
        .load      (hash_load),
        .key_text  (s_key_text),
        .key_canon (key_canon),
        .hash_val  (hash_val),
        .step_val  (step_val)
    );

    // hash mod table_size
    dhts_rem #(
        .DIVIDEND_W (HASH_W),
        .DIVISOR_W  (SZ_W)
    ) u_rem_hash (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (rem_start),
        .dividend  (hash_val),
        .divisor   (size_reg),
        .busy      (h_busy),
        .remainder (h_rem)
    );

    // step mod table_size
    dhts_rem #(
        .DIVIDEND_W (STEP_W),
        .DIVISOR_W  (SZ_W)
    ) u_rem_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (rem_start),
        .dividend  (step_val),
        .divisor   (size_reg),
        .busy      (st_busy),
        .remainder (st_rem)
    );

    dhts_store #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_W       (KEY_W)
    ) u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .wr          (wr),
        .wr_addr     (wr_addr),
        .kv_wdata    (kv_wdata),
        .flags_wdata (flags_wdata),
        .kv_rdata    (kv_rdata),
        .flags_rdata (flags_rdata),
        .clear_busy  (clear_busy)
    );

    dhts_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_W       (KEY_W)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_item_value (s_item_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_slot_index (m_slot_index),
        .m_item_out   (item_out),
        .size         (size_reg),
        .key_canon    (key_canon),
        .rem_start    (rem_start),
        .h_busy       (h_busy),
        .h_rem        (h_rem),
        .st_busy      (st_busy),
        .st_rem       (st_rem),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .wr           (wr),
        .wr_addr      (wr_addr),
        .kv_wdata     (kv_wdata),
        .flags_wdata  (flags_wdata),
        .kv_rdata     (kv_rdata),
        .flags_rdata  (flags_rdata),
        .clear_busy   (clear_busy)
    );

    assign m_item_out = item_out;

endmodule
